FILE: design/spq_pkg.sv
// Package for the sorted priority queue: sizes, status codes and the
// entry and command types shared by the cell and the top level.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int DEPTH     = 16;
	localparam int TAG_BITS  = 16;
	localparam int PRIO_BITS = 8;
	// count holds 0..DEPTH
	localparam int CNT_W     = $clog2(DEPTH + 1);

	// operation codes
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	// result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [TAG_BITS-1:0]  tag;
		logic [PRIO_BITS-1:0] prio;
	} entry_t;

	// command broadcast to every cell for one transfer
	typedef struct packed {
		logic                 enq;
		logic                 deq;
		logic [TAG_BITS-1:0]  tag;
		logic [PRIO_BITS-1:0] prio;
	} cmd_t;

endpackage

FILE: design/spq_cell.sv
// One slot of the sorted priority queue: holds an entry, compares it with
// an incoming priority and shifts toward either neighbor.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell (
	input  logic           clk,
	input  spq_pkg::cmd_t  cmd,
	input  logic           occ,      // slot holds a live entry
	input  logic           tail,     // slot is the first free one
	input  logic           lt_left,  // left neighbor moves back on insert
	input  spq_pkg::entry_t left_entry,
	input  spq_pkg::entry_t right_entry,
	output logic           lt,
	output spq_pkg::entry_t entry
);

	spq_pkg::entry_t entry_q;

	// live entry ranks below the incoming one, so it moves back
	assign lt    = occ && (entry_q.prio < cmd.prio);
	assign entry = entry_q;

	// insert: take the left neighbor if it moves back, else the new entry
	// remove: take the right neighbor
	always_ff @(posedge clk) begin
		if (cmd.enq && (lt || tail)) begin
			if (lt_left) begin
				entry_q <= left_entry;
			end else begin
				entry_q.tag  <= cmd.tag;
				entry_q.prio <= cmd.prio;
			end
		end else if (cmd.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule

FILE: design/sorted_priority_queue.sv
// Sorted priority queue: top level with the row of slot cells, the entry
// count and the result register.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   Present operation, tag and priority_req with start high; the command is
//   taken at the clock edge where start is high and busy is low. busy never
//   rises, so one command can be given in every cycle.
//   operation 0 inserts the entry behind all entries of equal or higher
//   priority; operation 1 removes the front (highest priority) entry.
//   Exactly one result follows each command, in the next cycle: done is high
//   for one cycle with status, out_tag, out_priority and occupancy.
//   The receiver cannot hold a result off; it must take it when done is high.
//   Throughput is one command per cycle: every slot cell compares and
//   shifts at the clock edge where the command is taken, so insert and
//   remove both take effect at that edge.
//   A full queue drops an insert and reports full; a remove on an empty
//   queue reports empty. Neither changes the contents.
//   Reset empties the queue and clears done; slot contents are not cleared
//   and are never shown before being written.
`timescale 1ns / 1ps

module sorted_priority_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [spq_pkg::TAG_BITS-1:0]  tag,
	input  logic [spq_pkg::PRIO_BITS-1:0] priority_req,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [spq_pkg::TAG_BITS-1:0]  out_tag,
	output logic [spq_pkg::PRIO_BITS-1:0] out_priority,
	output logic [spq_pkg::CNT_W-1:0]     occupancy
);

	localparam int D = spq_pkg::DEPTH;

	logic [spq_pkg::CNT_W-1:0] count_q;
	logic                      done_q;
	logic [1:0]                status_q;
	spq_pkg::entry_t           out_q;
	logic [spq_pkg::CNT_W-1:0] occ_out_q;

	logic            accept;
	logic            full;
	logic            empty;
	spq_pkg::cmd_t   cmd;
	logic            lt_v [D];
	spq_pkg::entry_t ent_v [D];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == spq_pkg::CNT_W'(D));
	assign empty  = (count_q == '0);

	// command to the cells, gated by full and empty
	always_comb begin
		cmd.enq  = accept && (operation == spq_pkg::OP_ENQ) && !full;
		cmd.deq  = accept && (operation == spq_pkg::OP_DEQ) && !empty;
		cmd.tag  = tag;
		cmd.prio = priority_req;
	end

	// row of slot cells, slot 0 at the front
	for (genvar i = 0; i < D; i++) begin : g_cell
		logic            occ;
		logic            tail;
		logic            lt_left;
		spq_pkg::entry_t left_e;
		spq_pkg::entry_t right_e;

		assign occ  = (spq_pkg::CNT_W'(i) < count_q);
		assign tail = (spq_pkg::CNT_W'(i) == count_q);

		if (i == 0) begin : g_first
			assign lt_left = 1'b0;
			assign left_e  = '0;
		end else begin : g_mid
			assign lt_left = lt_v[i-1];
			assign left_e  = ent_v[i-1];
		end

		if (i == D - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_rest
			assign right_e = ent_v[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occ         (occ),
			.tail        (tail),
			.lt_left     (lt_left),
			.left_entry  (left_e),
			.right_entry (right_e),
			.lt          (lt_v[i]),
			.entry       (ent_v[i])
		);
	end

	// entry count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (cmd.enq) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.deq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			if (operation == spq_pkg::OP_ENQ) begin
				status_q  <= full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
				occ_out_q <= full ? count_q : count_q + 1'b1;
				out_q     <= '0;
			end else if (empty) begin
				status_q  <= spq_pkg::ST_EMPTY;
				occ_out_q <= count_q;
				out_q     <= '0;
			end else begin
				status_q  <= spq_pkg::ST_DONE;
				occ_out_q <= count_q - 1'b1;
				out_q     <= ent_v[0];
			end
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign out_tag      = out_q.tag;
	assign out_priority = out_q.prio;
	assign occupancy    = occ_out_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spq_pkg::CNT_W'(D))
		else $error("entry count exceeds depth");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted command gave no result");

	a_occ_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> occupancy == count_q)
		else $error("reported occupancy differs from entry count");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == spq_pkg::ST_FULL) |-> occupancy == spq_pkg::CNT_W'(D))
		else $error("full status with queue not full");

	a_front_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= spq_pkg::CNT_W'(2)) |-> ent_v[0].prio >= ent_v[1].prio)
		else $error("front entries out of order");

endmodule
